### design/ascii_reply_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// ascii_reply_frame_parser_macros : assertion macros
// Concurrent check helpers that sample on i_clk and sleep while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCII_REPLY_FRAME_PARSER_MACROS_SVH
`define ASCII_REPLY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define ARFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ARFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/arfp_pkg.sv
// ----------------------------------------------------------------------------
// arfp_pkg : shared types and constants of the reply frame parser
// Item and result layouts, codes, characters and hex helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package arfp_pkg;

    // Item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result status codes
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_NG      = 3'd1;
    localparam logic [2:0] STATUS_INVALID = 3'd2;
    localparam logic [2:0] STATUS_PARTIAL = 3'd3;
    localparam logic [2:0] STATUS_NO_DATA = 3'd4;

    // Head word codes
    localparam logic [1:0] HEAD_NONE = 2'd0;
    localparam logic [1:0] HEAD_OK   = 2'd1;
    localparam logic [1:0] HEAD_NG   = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [15:0] WORD_OK   = 16'h4F4B;
    localparam logic [15:0] WORD_NG   = 16'h4E47;

    localparam logic [15:0] SUM_INIT      = 16'hFFFF;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [2:0]  TOKEN_MAX     = 3'd4;
    localparam logic [6:0]  TOKPOS_MAX    = 7'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value;
        logic        has_value;
        logic [31:0] frame_count;
        logic [31:0] error_count;
    } t_result;

    typedef struct packed {
        logic        done;
        logic [15:0] value;
    } t_check;

    // Hex digit value, 16 for a non-digit.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        return d;
    endfunction

    // Byte from a digit pair: non-digit first gives 0, non-digit second
    // gives the first digit alone.
    function automatic logic [7:0] pair_byte(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] a;
        logic [4:0] b;
        logic [7:0] r;
        a = hex_of(hi);
        b = hex_of(lo);
        if (a[4]) r = 8'h00;
        else if (b[4]) r = {4'h0, a[3:0]};
        else r = {a[3:0], b[3:0]};
        return r;
    endfunction

    // Shift one check digit in; stop at the first non-digit.
    function automatic t_check check_step(input t_check cur, input logic [7:0] c);
        logic [4:0] d;
        t_check r;
        d = hex_of(c);
        r = cur;
        if (!cur.done) begin
            if (d[4]) r.done = 1'b1;
            else r.value = {cur.value[11:0], d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/arfp_in_reg.sv
// ----------------------------------------------------------------------------
// arfp_in_reg : input register
// Holds one accepted item until the parse stage can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire arfp_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_fire,
    output arfp_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    arfp_pkg::t_item r_item;
    logic            w_load;

    // Stall only while a held item cannot move on.
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;
    assign o_fire  = r_valid && i_advance;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_load) n_valid = 1'b1;
        else if (i_advance) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_item <= i_item;
    end

endmodule

`default_nettype wire

### design/arfp_core.sv
// ----------------------------------------------------------------------------
// arfp_core : line parse state and result logic
// Tokenizes reply bytes, tracks the timeout and forms one result per wait.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_core #(
    parameter int LINE_LIMIT = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [15:0]      i_cfg_wr_data,
    input  wire logic             i_fire,
    input  wire arfp_pkg::t_item  i_item,
    output logic                  o_res_valid,
    output arfp_pkg::t_result     o_res
);

    localparam int LEN_W = $clog2(LINE_LIMIT);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LIMIT - 1);

    logic [15:0]      r_timeout;
    logic             r_armed,      n_armed;
    logic [LEN_W-1:0] r_line_len,   n_line_len;
    logic [15:0]      r_elapsed,    n_elapsed;
    logic [2:0]       r_tok_cnt,    n_tok_cnt;
    logic             r_tok_open,   n_tok_open;
    logic [6:0]       r_tok_pos,    n_tok_pos;
    logic [15:0]      r_first,      n_first;
    logic [7:0]       r_held,       n_held;
    logic [15:0]      r_data,       n_data;
    logic [15:0]      r_sum,        n_sum;
    logic [15:0]      r_rcv,        n_rcv;
    logic             r_chk_done,   n_chk_done;
    logic [31:0]      r_frames,     n_frames;
    logic [31:0]      r_errors,     n_errors;
    logic             r_text_end,   n_text_end;
    logic [1:0]       r_head,       n_head;
    logic             r_prefix,     n_prefix;
    logic             r_data_good,  n_data_good;

    logic             do_close;
    logic [2:0]       cl_cnt;
    logic [6:0]       cl_len;
    logic             is_cr;
    logic [7:0]       c;
    logic [7:0]       pb;
    arfp_pkg::t_check chk;

    assign c = i_item.rx_byte;

    always_comb begin
        n_armed     = r_armed;
        n_line_len  = r_line_len;
        n_elapsed   = r_elapsed;
        n_tok_cnt   = r_tok_cnt;
        n_tok_open  = r_tok_open;
        n_tok_pos   = r_tok_pos;
        n_first     = r_first;
        n_held      = r_held;
        n_data      = r_data;
        n_sum       = r_sum;
        n_rcv       = r_rcv;
        n_chk_done  = r_chk_done;
        n_frames    = r_frames;
        n_errors    = r_errors;
        n_text_end  = r_text_end;
        n_head      = r_head;
        n_prefix    = r_prefix;
        n_data_good = r_data_good;
        do_close    = 1'b0;
        cl_cnt      = r_tok_cnt;
        cl_len      = r_tok_pos;
        is_cr       = 1'b0;
        pb          = 8'h00;
        chk         = '{done: r_chk_done, value: r_rcv};
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            unique case (i_item.kind)
                arfp_pkg::KIND_START: begin
                    n_armed     = 1'b1;
                    n_line_len  = '0;
                    n_elapsed   = '0;
                    n_tok_cnt   = '0;
                    n_tok_open  = 1'b0;
                    n_tok_pos   = '0;
                    n_first     = '0;
                    n_held      = '0;
                    n_data      = '0;
                    n_sum       = arfp_pkg::SUM_INIT;
                    n_rcv       = '0;
                    n_chk_done  = 1'b0;
                    n_text_end  = 1'b0;
                    n_head      = arfp_pkg::HEAD_NONE;
                    n_prefix    = 1'b0;
                    n_data_good = 1'b0;
                end
                arfp_pkg::KIND_TICK: begin
                    if (r_armed) begin
                        if (r_elapsed < arfp_pkg::TICK_MAX) n_elapsed = r_elapsed + 16'd1;
                        if (n_elapsed >= r_timeout) begin
                            o_res_valid   = 1'b1;
                            o_res.status  = (r_line_len == '0) ? arfp_pkg::STATUS_NO_DATA
                                                               : arfp_pkg::STATUS_PARTIAL;
                            n_errors      = r_errors + 32'd1;
                            n_armed       = 1'b0;
                        end
                    end
                end
                arfp_pkg::KIND_BYTE: begin
                    if (r_armed) begin
                        if (r_line_len >= LEN_MAX) begin
                            o_res_valid  = 1'b1;
                            o_res.status = arfp_pkg::STATUS_INVALID;
                            n_errors     = r_errors + 32'd1;
                            n_armed      = 1'b0;
                        end else if (c != arfp_pkg::CHAR_CR) begin
                            n_line_len = r_line_len + LEN_W'(1);
                            if (!r_text_end) begin
                                if (c == arfp_pkg::CHAR_NUL) begin
                                    do_close   = r_tok_open;
                                    n_text_end = 1'b1;
                                end else if (c == arfp_pkg::CHAR_SPACE) begin
                                    if (r_tok_open) begin
                                        do_close = 1'b1;
                                    end else if (r_tok_cnt < arfp_pkg::TOKEN_MAX) begin
                                        // Empty token: open and close at once.
                                        n_tok_cnt = r_tok_cnt + 3'd1;
                                        n_tok_pos = '0;
                                        do_close  = 1'b1;
                                        cl_cnt    = n_tok_cnt;
                                        cl_len    = '0;
                                    end
                                end else if (r_tok_open || r_tok_cnt < arfp_pkg::TOKEN_MAX) begin
                                    if (!r_tok_open) begin
                                        n_tok_cnt  = r_tok_cnt + 3'd1;
                                        n_tok_open = 1'b1;
                                        n_tok_pos  = '0;
                                    end
                                    case (n_tok_cnt)
                                        3'd1: begin
                                            if (n_tok_pos == 7'd0) n_first = {c, 8'h00};
                                            else if (n_tok_pos == 7'd1) n_first = {r_first[15:8], r_first[7:0] | c};
                                        end
                                        3'd2: begin
                                            if (!n_tok_pos[0]) begin
                                                n_held = c;
                                            end else if (n_tok_pos == 7'd1 && r_held == arfp_pkg::CHAR_P
                                                         && c == arfp_pkg::CHAR_EQ) begin
                                                n_prefix = 1'b1;
                                            end else begin
                                                pb     = arfp_pkg::pair_byte(r_held, c);
                                                n_sum  = r_sum - {8'h00, pb};
                                                n_data = {r_data[7:0], pb};
                                            end
                                        end
                                        3'd3: begin
                                            if (n_tok_pos == 7'd0) begin
                                                n_held = c;
                                            end else if (n_tok_pos == 7'd1) begin
                                                if (!(r_held == arfp_pkg::CHAR_C && c == arfp_pkg::CHAR_EQ)) begin
                                                    chk = arfp_pkg::check_step(chk, r_held);
                                                    chk = arfp_pkg::check_step(chk, c);
                                                end
                                            end else begin
                                                chk = arfp_pkg::check_step(chk, c);
                                            end
                                            n_chk_done = chk.done;
                                            n_rcv      = chk.value;
                                        end
                                        default: begin
                                        end
                                    endcase
                                    if (n_tok_pos < arfp_pkg::TOKPOS_MAX) n_tok_pos = n_tok_pos + 7'd1;
                                end
                            end
                        end else begin
                            is_cr    = 1'b1;
                            do_close = r_tok_open;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Close the current token.
            if (do_close) begin
                n_tok_open = 1'b0;
                case (cl_cnt)
                    3'd1: begin
                        n_head = arfp_pkg::HEAD_NONE;
                        if (cl_len == 7'd2 && r_first == arfp_pkg::WORD_OK) n_head = arfp_pkg::HEAD_OK;
                        if (cl_len == 7'd2 && r_first == arfp_pkg::WORD_NG) n_head = arfp_pkg::HEAD_NG;
                    end
                    3'd2: begin
                        n_data_good = !cl_len[0] && (cl_len >= (r_prefix ? 7'd4 : 7'd2));
                    end
                    3'd3: begin
                        if (cl_len == 7'd1) begin
                            chk        = arfp_pkg::check_step('{done: r_chk_done, value: r_rcv}, r_held);
                            n_chk_done = chk.done;
                            n_rcv      = chk.value;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Judge the finished line.
            if (is_cr) begin
                o_res_valid = 1'b1;
                n_armed     = 1'b0;
                n_frames    = r_frames + 32'd1;
                if (n_tok_cnt == 3'd0 || n_head == arfp_pkg::HEAD_NONE) begin
                    o_res.status = arfp_pkg::STATUS_INVALID;
                    n_errors     = r_errors + 32'd1;
                end else if (n_tok_cnt == 3'd1 && n_head == arfp_pkg::HEAD_OK) begin
                    o_res.status = arfp_pkg::STATUS_OK;
                end else if (n_tok_cnt != 3'd3) begin
                    o_res.status = arfp_pkg::STATUS_INVALID;
                    n_errors     = r_errors + 32'd1;
                end else begin
                    o_res.status = (n_head == arfp_pkg::HEAD_OK) ? arfp_pkg::STATUS_OK
                                                                 : arfp_pkg::STATUS_NG;
                    if (n_data_good) begin
                        o_res.value     = r_data;
                        o_res.has_value = 1'b1;
                        if (n_rcv != r_sum) begin
                            o_res.status = arfp_pkg::STATUS_INVALID;
                            n_errors     = r_errors + 32'd1;
                        end
                    end
                end
            end
        end

        o_res.frame_count = n_frames;
        o_res.error_count = n_errors;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= arfp_pkg::TIMEOUT_RESET;
            r_armed     <= 1'b0;
            r_line_len  <= '0;
            r_elapsed   <= '0;
            r_tok_cnt   <= '0;
            r_tok_open  <= 1'b0;
            r_tok_pos   <= '0;
            r_first     <= '0;
            r_held      <= '0;
            r_data      <= '0;
            r_sum       <= arfp_pkg::SUM_INIT;
            r_rcv       <= '0;
            r_chk_done  <= 1'b0;
            r_frames    <= '0;
            r_errors    <= '0;
            r_text_end  <= 1'b0;
            r_head      <= arfp_pkg::HEAD_NONE;
            r_prefix    <= 1'b0;
            r_data_good <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_timeout <= i_cfg_wr_data;
            r_armed     <= n_armed;
            r_line_len  <= n_line_len;
            r_elapsed   <= n_elapsed;
            r_tok_cnt   <= n_tok_cnt;
            r_tok_open  <= n_tok_open;
            r_tok_pos   <= n_tok_pos;
            r_first     <= n_first;
            r_held      <= n_held;
            r_data      <= n_data;
            r_sum       <= n_sum;
            r_rcv       <= n_rcv;
            r_chk_done  <= n_chk_done;
            r_frames    <= n_frames;
            r_errors    <= n_errors;
            r_text_end  <= n_text_end;
            r_head      <= n_head;
            r_prefix    <= n_prefix;
            r_data_good <= n_data_good;
        end
    end

endmodule

`default_nettype wire

### design/arfp_out_reg.sv
// ----------------------------------------------------------------------------
// arfp_out_reg : result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire arfp_pkg::t_result i_res,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output arfp_pkg::t_result      o_res
);

    logic              r_valid;
    logic              n_valid;
    arfp_pkg::t_result r_res;

    // Free when empty or being taken this cycle.
    assign o_ready = !(r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) n_valid = 1'b1;
        else if (o_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

endmodule

`default_nettype wire

### design/ascii_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_reply_frame_parser : reply line parser with timeout and statistics
// Arms on a start item, parses reply bytes up to a carriage return, checks
// the checksum and reports status, data and running frame and error counts.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   -------   ---------  -------------------------  ---------------------------
//   input     in         i_in_valid / o_in_stall    i_kind, i_rx_byte
//   result    out        o_out_valid / i_out_stall  o_status, o_value,
//                                                   o_has_value, o_frame_count,
//                                                   o_error_count
//   config    in         i_cfg_wr_en                i_cfg_wr_data (timeout_ms)
//
// One item per cycle is taken while o_in_stall is low; the parse stage between the
// input register and the result register settles each item combinationally, so an
// item passes the input register and then the result register to reach the outputs.
// Reset is synchronous, active low; it clears all parse state and sets the
// timeout to 1000 ticks. No memory, so no clearing pass.
// A stalled result holds in the result register; the input register then
// holds its item and o_in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_reply_frame_parser_macros.svh"

module ascii_reply_frame_parser #(
    parameter int LINE_LIMIT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_value,
    output logic             o_has_value,
    output logic [31:0]      o_frame_count,
    output logic [31:0]      o_error_count,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    arfp_pkg::t_item   w_in_item;
    arfp_pkg::t_item   w_item;
    arfp_pkg::t_result w_res;
    arfp_pkg::t_result w_out_res;
    logic              w_fire;
    logic              w_res_valid;
    logic              w_out_ready;

    assign w_in_item = '{kind: i_kind, rx_byte: i_rx_byte};

    // Hold the accepted item; advance only when the result register is free.
    arfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (w_in_item),
        .i_advance (w_out_ready),
        .o_fire    (w_fire),
        .o_item    (w_item)
    );

    // Parse state, timeout and counters; one pass per item.
    arfp_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_fire),
        .i_item        (w_item),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Hold the result while the consumer stalls.
    arfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_status      = w_out_res.status;
    assign o_value       = w_out_res.value;
    assign o_has_value   = w_out_res.has_value;
    assign o_frame_count = w_out_res.frame_count;
    assign o_error_count = w_out_res.error_count;

    // A new result never lands on one that is still stalled.
    `ARFP_ASSERT_IMP(a_res_has_room, w_res_valid, w_out_ready, "result overwrites a held result")
    // Input stalls only while the result register is not free and no item fires.
    `ARFP_ASSERT_IMP(a_stall_needs_item, o_in_stall, !w_fire && !w_out_ready, "input stall without cause")
    // A valid result without a decoded value carries a zero value.
    `ARFP_ASSERT_IMP(a_value_zero, o_out_valid && !o_has_value, o_value == 16'h0000, "value without data")
    // A taken result with nothing new behind it leaves the output empty.
    `ARFP_ASSERT_NXT(a_drain, o_out_valid && !i_out_stall && !w_res_valid, !o_out_valid, "result repeated")

endmodule

`default_nettype wire
